// ----- hdl/bfst_pkg.sv -----
// Shared types and constants for the best-fit span table.
// Used by the controller, datapath and top level; no dependencies.
package bfst_pkg;

    localparam int PAGE_BITS        = 32;
    localparam int ADDR_BITS        = 48;
    localparam int CAPACITY_DEFAULT = 64;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_DUP      = 2'd3;

    typedef struct packed {
        logic [1:0]           opcode;
        logic [PAGE_BITS-1:0] req_pages;
        logic [ADDR_BITS-1:0] start_addr;
    } t_in_item;

    typedef struct packed {
        logic [1:0]           status;
        logic [PAGE_BITS-1:0] span_pages;
        logic [ADDR_BITS-1:0] span_start;
    } t_out_item;

    // One table slot as held in memory
    typedef struct packed {
        logic                 valid;
        logic [PAGE_BITS-1:0] pages;
        logic [ADDR_BITS-1:0] start;
    } t_entry;

    typedef struct packed {
        logic clear_wr;   // write an empty slot at the sweep address
        logic load;       // capture the input transaction, reset trackers
        logic read;       // issue a scan read at the sweep address
        logic commit;     // write back and load the result register
    } t_cmd;

    typedef struct packed {
        logic addr_last;  // sweep address is at the last slot
        logic out_busy;   // result register still holds an untaken result
    } t_sts;

endpackage

// ----- hdl/bfst_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module bfst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/bfst_dp.sv -----
// Datapath of the best-fit span table: slot memory, sweep counter, scan
// trackers, write-back and result register. Depends on bfst_pkg, bfst_ram.
module bfst_dp #(
    parameter int CAPACITY = bfst_pkg::CAPACITY_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bfst_pkg::t_cmd      i_cmd,
    output bfst_pkg::t_sts      o_sts,
    input  bfst_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output bfst_pkg::t_out_item o_out_item
);
    import bfst_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [AW-1:0]  r_addr;
    logic [AW-1:0]  r_rd_idx;
    logic           r_rd_vld;
    logic [CW-1:0]  r_count;
    t_in_item       r_in;

    logic           r_hit;
    logic [AW-1:0]  r_hit_idx;
    logic           r_free_ok;
    logic [AW-1:0]  r_free_idx;
    logic           r_best_ok;
    logic [PAGE_BITS-1:0] r_best_pages;
    logic [ADDR_BITS-1:0] r_best_start;

    logic           r_out_valid;
    t_out_item      r_out_item;

    t_entry         rd_entry;
    logic [$bits(t_entry)-1:0] rd_word;
    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    t_entry         ram_wdata;

    logic           cm_we;
    logic [AW-1:0]  cm_addr;
    t_entry         cm_data;
    t_out_item      n_out;
    logic           cm_inc;
    logic           cm_dec;

    logic           addr_last;
    logic           is_hit;
    logic           is_fit;
    logic           is_better;

    assign addr_last = (r_addr == AW'(CAPACITY - 1));
    assign o_sts.addr_last = addr_last;
    assign o_sts.out_busy  = r_out_valid & ~i_out_ready;

    bfst_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.read),
        .i_raddr (r_addr),
        .o_rdata (rd_word)
    );

    assign rd_entry = t_entry'(rd_word);

    // Scan compares on the entry returned for r_rd_idx
    assign is_hit = rd_entry.valid && (rd_entry.pages == r_in.req_pages)
                    && (rd_entry.start == r_in.start_addr);
    assign is_fit = rd_entry.valid && (rd_entry.pages >= r_in.req_pages);
    assign is_better = !r_best_ok || (rd_entry.pages < r_best_pages)
                       || ((rd_entry.pages == r_best_pages)
                           && (rd_entry.start < r_best_start));

    // Write-back and result for the captured transaction
    always_comb begin
        cm_we   = 1'b0;
        cm_addr = r_free_idx;
        cm_data = '0;
        cm_inc  = 1'b0;
        cm_dec  = 1'b0;
        n_out   = '0;
        unique case (r_in.opcode)
            OP_INSERT: begin
                if (r_hit) begin
                    n_out.status = ST_DUP;
                end else if ((r_count >= CW'(CAPACITY)) || !r_free_ok) begin
                    n_out.status = ST_FULL;
                end else begin
                    cm_we         = 1'b1;
                    cm_data.valid = 1'b1;
                    cm_data.pages = r_in.req_pages;
                    cm_data.start = r_in.start_addr;
                    cm_inc        = 1'b1;
                    n_out.status  = ST_OK;
                end
            end
            OP_REMOVE: begin
                if (r_hit) begin
                    cm_we        = 1'b1;
                    cm_addr      = r_hit_idx;
                    cm_dec       = (r_count != '0);
                    n_out.status = ST_OK;
                end else begin
                    n_out.status = ST_NOTFOUND;
                end
            end
            OP_LOOKUP: begin
                if (r_best_ok) begin
                    n_out.status     = ST_OK;
                    n_out.span_pages = r_best_pages;
                    n_out.span_start = r_best_start;
                end else begin
                    n_out.status = ST_NOTFOUND;
                end
            end
            default: begin
                n_out.status = ST_OK;
            end
        endcase
    end

    assign ram_we    = i_cmd.clear_wr | (i_cmd.commit & cm_we);
    assign ram_waddr = i_cmd.commit ? cm_addr : r_addr;
    assign ram_wdata = i_cmd.commit ? cm_data : t_entry'('0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr      <= '0;
            r_rd_vld    <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_hit       <= 1'b0;
            r_free_ok   <= 1'b0;
            r_best_ok   <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.read;
            if (i_cmd.clear_wr || i_cmd.read) begin
                r_addr <= addr_last ? '0 : r_addr + AW'(1);
            end

            if (i_cmd.load) begin
                r_hit     <= 1'b0;
                r_free_ok <= 1'b0;
                r_best_ok <= 1'b0;
            end else if (r_rd_vld) begin
                if (is_hit && !r_hit) begin
                    r_hit <= 1'b1;
                end
                if (!rd_entry.valid && !r_free_ok) begin
                    r_free_ok <= 1'b1;
                end
                if (is_fit && is_better) begin
                    r_best_ok <= 1'b1;
                end
            end

            if (i_cmd.commit) begin
                if (cm_inc) begin
                    r_count <= r_count + CW'(1);
                end else if (cm_dec) begin
                    r_count <= r_count - CW'(1);
                end
            end

            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_addr;
        if (i_cmd.load) begin
            r_in <= i_in_item;
        end
        if (r_rd_vld) begin
            if (is_hit && !r_hit) begin
                r_hit_idx <= r_rd_idx;
            end
            if (!rd_entry.valid && !r_free_ok) begin
                r_free_idx <= r_rd_idx;
            end
            if (is_fit && is_better) begin
                r_best_pages <= rd_entry.pages;
                r_best_start <= rd_entry.start;
            end
        end
        if (i_cmd.commit) begin
            r_out_item <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ----- hdl/bfst_ctrl.sv -----
// Controller of the best-fit span table: clearing sweep, scan sequencing
// and commit timing. Depends on bfst_pkg.
module bfst_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  bfst_pkg::t_sts i_sts,
    output bfst_pkg::t_cmd o_cmd
);
    import bfst_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_COMMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_sts.addr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid && r_in_ready) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.read = 1'b1;
                if (i_sts.addr_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // last read word lands in the trackers here
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                // hold until the previous result has been taken
                if (!i_sts.out_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_in_ready <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == S_IDLE);
        end
    end

    assign o_in_ready = r_in_ready;

endmodule

// ----- hdl/best_fit_span_table.sv -----
// Best-fit span table: insert, remove and lower-bound lookup over a set of
// (page count, start) spans. A new transaction is accepted only after the
// previous one has been committed; the scan through the slot memory read port
// takes one slot per cycle, and the commit waits while a result is untaken.
// Reset: synchronous; a clearing sweep empties every slot, with o_in_ready
// low until it ends. Depends on bfst_pkg, bfst_ctrl, bfst_dp.
module best_fit_span_table #(
    parameter int CAPACITY = bfst_pkg::CAPACITY_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  bfst_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output bfst_pkg::t_out_item o_out_item
);
    import bfst_pkg::*;

    t_cmd cmd;
    t_sts sts;

    bfst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bfst_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

// ----- dv/tb_best_fit_span_table.sv -----
// Testbench for best_fit_span_table: directed and random insert/remove/lookup traffic
// checked against a behavioral span table kept in the bench.
// Depends on bfst_pkg and the best_fit_span_table RTL.
`timescale 1ns / 1ps

module tb_best_fit_span_table;
    import bfst_pkg::*;

    localparam int         CAP         = CAPACITY_DEFAULT;
    localparam int         LATENCY     = CAP + 3;
    localparam int         HOLD_CYCLES = 600;
    localparam logic [1:0] OP_UNUSED   = 2'd3;

    localparam logic [PAGE_BITS-1:0] PAGES_MAX = '1;
    localparam logic [ADDR_BITS-1:0] ADDR_MAX  = '1;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_item   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;

    best_fit_span_table #(
        .CAPACITY (CAP)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // Shadow copy of the span table
    logic [PAGE_BITS-1:0] slot_pages [CAP];
    logic [ADDR_BITS-1:0] slot_start [CAP];
    bit                   slot_live  [CAP];
    int                   live_count = 0;
    int                   peak_live  = 0;

    t_out_item span_result_q [$];
    t_out_item want;

    int errors      = 0;
    int n_sent      = 0;
    int n_checked   = 0;
    int op_sent     [4];
    int status_seen [4];

    // Traffic shaping knobs, changed per test
    int gap_max       = 0;
    int burst_left    = 0;
    int stall_pct     = 0;
    int stall_max     = 100;
    bit hold_request  = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("%0t: timeout", $time);
        $display("Some tests failed");
        $finish;
    end

    function automatic int find_span(input logic [PAGE_BITS-1:0] pages,
                                     input logic [ADDR_BITS-1:0] start);
        for (int i = 0; i < CAP; i++) begin
            if (slot_live[i] && slot_pages[i] == pages && slot_start[i] == start)
                return i;
        end
        return -1;
    endfunction

    function automatic t_out_item predict_span_op(input t_in_item item);
        t_out_item res;
        int        idx;
        int        best;
        res  = '0;
        best = -1;
        case (item.opcode)
            OP_INSERT: begin
                if (find_span(item.req_pages, item.start_addr) >= 0) begin
                    res.status = ST_DUP;
                end else if (live_count >= CAP) begin
                    res.status = ST_FULL;
                end else begin
                    res.status = ST_FULL;
                    for (int i = 0; i < CAP; i++) begin
                        if (!slot_live[i]) begin
                            slot_live[i]  = 1'b1;
                            slot_pages[i] = item.req_pages;
                            slot_start[i] = item.start_addr;
                            live_count++;
                            res.status = ST_OK;
                            break;
                        end
                    end
                    if (live_count > peak_live)
                        peak_live = live_count;
                end
            end
            OP_REMOVE: begin
                idx = find_span(item.req_pages, item.start_addr);
                if (idx < 0) begin
                    res.status = ST_NOTFOUND;
                end else begin
                    slot_live[idx] = 1'b0;
                    live_count--;
                    res.status = ST_OK;
                end
            end
            OP_LOOKUP: begin
                for (int i = 0; i < CAP; i++) begin
                    if (!slot_live[i] || slot_pages[i] < item.req_pages)
                        continue;
                    if (best < 0 || slot_pages[i] < slot_pages[best] ||
                        (slot_pages[i] == slot_pages[best] &&
                         slot_start[i] < slot_start[best]))
                        best = i;
                end
                if (best < 0) begin
                    res.status = ST_NOTFOUND;
                end else begin
                    res.status     = ST_OK;
                    res.span_pages = slot_pages[best];
                    res.span_start = slot_start[best];
                end
            end
            default: res = '0;
        endcase
        return res;
    endfunction

    // Offer one transaction in bursts with random gaps; predict on acceptance
    task automatic send_item(input t_in_item item);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_item  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        span_result_q.push_back(predict_span_op(item));
        op_sent[item.opcode]++;
        n_sent++;
    endtask

    task automatic send_op(input logic [1:0] op, input logic [PAGE_BITS-1:0] pages,
                           input logic [ADDR_BITS-1:0] start);
        t_in_item item;
        item.opcode     = op;
        item.req_pages  = pages;
        item.start_addr = start;
        send_item(item);
    endtask

    function automatic logic [PAGE_BITS-1:0] rand_pages();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return PAGE_BITS'($urandom_range(0, 15));
        else if (r < 8)
            return PAGE_BITS'($urandom);
        else
            return PAGES_MAX - PAGE_BITS'($urandom_range(0, 15));
    endfunction

    function automatic logic [ADDR_BITS-1:0] rand_addr();
        logic [63:0] w;
        int          r;
        w = {$urandom, $urandom};
        r = $urandom_range(0, 9);
        if (r < 4)
            return ADDR_BITS'($urandom_range(0, 7));
        else if (r < 8)
            return w[ADDR_BITS-1:0];
        else
            return ADDR_MAX - ADDR_BITS'($urandom_range(0, 7));
    endfunction

    function automatic int pick_live_slot();
        int live_idx [$];
        for (int i = 0; i < CAP; i++) begin
            if (slot_live[i])
                live_idx.push_back(i);
        end
        if (live_idx.size() == 0)
            return -1;
        return live_idx[$urandom_range(0, live_idx.size() - 1)];
    endfunction

    // Result check: compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            status_seen[o_out_item.status]++;
            if (span_result_q.size() == 0) begin
                $display("%0t: unexpected result status=%0d pages=%h start=%h", $time,
                         o_out_item.status, o_out_item.span_pages, o_out_item.span_start);
                errors++;
            end else begin
                want = span_result_q.pop_front();
                n_checked++;
                if (o_out_item.status !== want.status) begin
                    $display("%0t: status mismatch: expected %0d, got %0d", $time,
                             want.status, o_out_item.status);
                    errors++;
                end
                if (o_out_item.span_pages !== want.span_pages) begin
                    $display("%0t: span_pages mismatch: expected %h, got %h", $time,
                             want.span_pages, o_out_item.span_pages);
                    errors++;
                end
                if (o_out_item.span_start !== want.span_start) begin
                    $display("%0t: span_start mismatch: expected %h, got %h", $time,
                             want.span_start, o_out_item.span_start);
                    errors++;
                end
            end
        end
    end

    // Output side: random ready/stall runs, plus a long hold on request
    initial begin
        int hold_left;
        int run_left;
        bit ready_run;
        hold_left = 0;
        run_left  = 0;
        ready_run = 1'b1;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                if (run_left == 0) begin
                    ready_run = ($urandom_range(0, 99) >= stall_pct);
                    run_left  = ready_run ? $urandom_range(1, 40) : $urandom_range(1, stall_max);
                end
                run_left--;
                i_out_ready <= ready_run;
            end
        end
    end

    task automatic test_empty_table();
        gap_max   = 0;
        stall_pct = 0;
        send_op(OP_LOOKUP, '0, '0);
        send_op(OP_LOOKUP, PAGES_MAX, ADDR_MAX);
        send_op(OP_REMOVE, 1, 1);
        send_op(OP_UNUSED, PAGES_MAX, ADDR_MAX);
    endtask

    task automatic test_extremes_and_ties();
        gap_max   = 20;
        stall_pct = 30;
        send_op(OP_INSERT, '0, '0);
        send_op(OP_INSERT, PAGES_MAX, ADDR_MAX);
        send_op(OP_INSERT, PAGES_MAX, ADDR_MAX);
        send_op(OP_LOOKUP, '0, ADDR_MAX);
        send_op(OP_LOOKUP, 1, '0);
        send_op(OP_LOOKUP, PAGES_MAX, '0);
        // equal page counts: lowest start must win
        send_op(OP_INSERT, 5, 100);
        send_op(OP_INSERT, 5, 50);
        send_op(OP_LOOKUP, 5, '0);
        send_op(OP_LOOKUP, 3, '0);
        send_op(OP_REMOVE, 5, 50);
        send_op(OP_LOOKUP, 5, '0);
        send_op(OP_REMOVE, 5, 50);
        send_op(OP_REMOVE, '0, '0);
        send_op(OP_LOOKUP, '0, '0);
        send_op(OP_UNUSED, '0, '0);
    endtask

    task automatic test_full_table();
        int slot;
        gap_max   = 4;
        stall_pct = 20;
        while (live_count < CAP)
            send_op(OP_INSERT, $urandom_range(16, 200), rand_addr());
        send_op(OP_INSERT, 7, 7);
        // duplicate is reported ahead of the full condition
        slot = pick_live_slot();
        send_op(OP_INSERT, slot_pages[slot], slot_start[slot]);
        send_op(OP_LOOKUP, '0, '0);
        send_op(OP_LOOKUP, 150, '0);
        slot = pick_live_slot();
        send_op(OP_REMOVE, slot_pages[slot], slot_start[slot]);
        send_op(OP_INSERT, 7, 7);
        send_op(OP_INSERT, 8, 8);
    endtask

    task automatic test_output_hold();
        gap_max      = 0;
        stall_pct    = 0;
        hold_request = 1'b1;
        repeat (14)
            send_op(2'($urandom_range(0, 2)), rand_pages(), rand_addr());
    endtask

    task automatic test_random_mix(input int n_items, input int insert_pct,
                                   input int gap_limit, input int stall_chance);
        t_in_item item;
        int       r;
        int       slot;
        gap_max   = gap_limit;
        stall_pct = stall_chance;
        repeat (n_items) begin
            r    = $urandom_range(0, 99);
            slot = pick_live_slot();
            item.req_pages  = rand_pages();
            item.start_addr = rand_addr();
            if (r < insert_pct) begin
                item.opcode = OP_INSERT;
                if (slot >= 0 && $urandom_range(0, 9) == 0) begin
                    item.req_pages  = slot_pages[slot];
                    item.start_addr = slot_start[slot];
                end
            end else if (r < insert_pct + (96 - insert_pct) / 2) begin
                item.opcode = OP_REMOVE;
                if (slot >= 0 && $urandom_range(0, 4) != 0) begin
                    item.req_pages = slot_pages[slot];
                    // near miss on the start now and then
                    item.start_addr = slot_start[slot] + ($urandom_range(0, 5) == 0);
                end
            end else if (r < 96) begin
                item.opcode = OP_LOOKUP;
                if (slot >= 0 && $urandom_range(0, 1) == 0)
                    item.req_pages = slot_pages[slot] + $urandom_range(0, 2) - 1;
            end else begin
                item.opcode = OP_UNUSED;
            end
            send_item(item);
        end
    endtask

    initial begin
        int waited;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_extremes_and_ties();
        test_full_table();
        test_output_hold();
        test_random_mix(100, 70, 90, 30);
        test_random_mix(80, 15, 40, 50);
        test_random_mix(60, 45, 0, 0);
        test_random_mix(70, 75, 10, 10);
        test_random_mix(70, 40, 70, 40);

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        stall_pct = 20;

        waited = 0;
        while (span_result_q.size() > 0 && waited < 50000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (LATENCY + 20) @(posedge i_clk);
        if (span_result_q.size() > 0) begin
            $display("%0t: %0d results never arrived", $time, span_result_q.size());
            errors++;
        end

        $display("Sent %0d transactions (insert %0d, remove %0d, lookup %0d, unused %0d),",
                 n_sent, op_sent[OP_INSERT], op_sent[OP_REMOVE], op_sent[OP_LOOKUP],
                 op_sent[OP_UNUSED]);
        $display("%0d checked; statuses ok %0d, not found %0d, full %0d, duplicate %0d;",
                 n_checked, status_seen[ST_OK], status_seen[ST_NOTFOUND],
                 status_seen[ST_FULL], status_seen[ST_DUP]);
        $display("peak occupancy %0d.", peak_live);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
